/* sv/ptfd_pkg.sv */
// Package for the PSK tag frame decoder: types, frame constants and decode helpers.
package ptfd_pkg;

    localparam int BUFFER_BYTES   = 16;
    localparam int BUF_BITS       = BUFFER_BYTES * 8;
    localparam int FRAME_BITS     = 64;
    localparam int LEN_W          = 17;
    localparam int CARD_W         = 29;
    localparam int FC_W           = 8;
    localparam int CN_W           = 16;
    localparam int PREAMBLE_LEN   = 33;
    localparam logic [PREAMBLE_LEN-1:0] PREAMBLE = 33'h140000001;
    localparam logic [LEN_W-1:0]  PHASE_SHIFT_US = 17'd120;

    typedef logic [LEN_W-1:0]    t_len;
    typedef logic [BUF_BITS-1:0] t_buf;
    typedef logic [CARD_W-1:0]   t_card;

    typedef enum logic [1:0] {
        PH_NORMAL   = 2'd0,
        PH_INVERTED = 2'd1,
        PH_SHIFTED  = 2'd2,
        PH_INV_SHIFTED = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PHASE,
        ST_SHIFT,
        ST_EMIT
    } t_state;

    // decoded-bit positions, most significant output bit first
    localparam logic [4:0] FC_MAP [FC_W] = '{5'd24, 5'd16, 5'd11, 5'd14,
                                             5'd15, 5'd20, 5'd6, 5'd25};
    localparam logic [4:0] CN_MAP [CN_W] = '{5'd9, 5'd12, 5'd10, 5'd7, 5'd19, 5'd3,
                                             5'd2, 5'd18, 5'd13, 5'd0, 5'd4, 5'd21,
                                             5'd23, 5'd26, 5'd17, 5'd8};

    // Stream bit k sits at vector bit BUF_BITS-1-k.
    function automatic logic frame_ok(input t_buf v);
        frame_ok = (v[127:95] == PREAMBLE) && (v[63:31] == PREAMBLE) && (v[67:66] == 2'b00);
    endfunction

    function automatic t_card card_of(input t_buf v);
        card_of = {v[94:68], v[65:64]};
    endfunction

    function automatic logic [FC_W-1:0] fc_of(input t_card c);
        logic [FC_W-1:0] r;
        r = '0;
        for (int i = 0; i < FC_W; i++) begin
            r[FC_W-1-i] = c[5'd28 - FC_MAP[i]];
        end
        fc_of = r;
    endfunction

    function automatic logic [CN_W-1:0] cn_of(input t_card c);
        logic [CN_W-1:0] r;
        r = '0;
        for (int i = 0; i < CN_W; i++) begin
            r[CN_W-1-i] = c[5'd28 - CN_MAP[i]];
        end
        cn_of = r;
    endfunction

endpackage

/* sv/ptfd_if.sv */
// Stream interfaces for pulse input and frame result transfers.
interface ptfd_pulse_if;
    logic        valid;
    logic        ready;
    logic        pulse_level;
    logic [15:0] pulse_duration;

    modport source (output valid, output pulse_level, output pulse_duration, input ready);
    modport sink   (input valid, input pulse_level, input pulse_duration, output ready);
endinterface

interface ptfd_result_if;
    logic        valid;
    logic        ready;
    logic        frame_found;
    logic [28:0] card_bits;
    logic [7:0]  facility_code;
    logic [15:0] card_number;
    logic [1:0]  matched_phase;

    modport source (output valid, output frame_found, output card_bits,
                    output facility_code, output card_number, output matched_phase,
                    input ready);
    modport sink   (input valid, input frame_found, input card_bits,
                    input facility_code, input card_number, input matched_phase,
                    output ready);
endinterface

/* sv/psk_tag_frame_decoder.sv */
// PSK tag frame decoder: one pulse in, one frame result out.
// Flow: a pulse no longer than half a bit period goes straight to ST_EMIT; otherwise each
//   phase in turn passes ST_PHASE, then shifts its bits in ST_SHIFT, until a frame matches.
// Throughput: one pulse at a time; the shared subtract/compare unit pushes one bit a cycle.
// Reset (synchronous, active low) clears all four shift registers and the output valid flag.
module psk_tag_frame_decoder #(
    parameter int BIT_PERIOD_US = 255
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ptfd_pulse_if.sink            i_pulse,
    ptfd_result_if.source         o_result
);

    localparam ptfd_pkg::t_len HALF_P  = ptfd_pkg::LEN_W'(BIT_PERIOD_US / 2);
    localparam ptfd_pkg::t_len PERIOD  = ptfd_pkg::LEN_W'(BIT_PERIOD_US);
    localparam ptfd_pkg::t_len LIMIT   = ptfd_pkg::LEN_W'(ptfd_pkg::FRAME_BITS * BIT_PERIOD_US);

    ptfd_pkg::t_state r_state, n_state;
    ptfd_pkg::t_buf   r_buf [4];
    ptfd_pkg::t_phase r_phase, n_phase;
    ptfd_pkg::t_len   r_rem, n_rem;
    ptfd_pkg::t_len   r_dur, n_dur;
    ptfd_pkg::t_len   r_adj, n_adj;
    logic             r_level, n_level;
    logic             r_hit, n_hit;
    ptfd_pkg::t_card  r_card, n_card;

    logic             r_out_valid;
    logic             r_out_found;
    ptfd_pkg::t_card  r_out_card;
    logic [7:0]       r_out_fc;
    logic [15:0]      r_out_cn;
    logic [1:0]       r_out_phase;

    ptfd_pkg::t_buf   shifted;
    logic             push_bit;
    logic             push;
    logic             emit;
    logic             in_xfer;
    ptfd_pkg::t_len   len_sel;
    ptfd_pkg::t_len   in_dur;

    assign in_dur   = {1'b0, i_pulse.pulse_duration};
    assign in_xfer  = i_pulse.valid && i_pulse.ready;
    assign push_bit = r_level ^ r_phase[0];
    assign shifted  = {r_buf[r_phase][ptfd_pkg::BUF_BITS-2:0], push_bit};
    assign len_sel  = r_phase[1] ? r_adj : r_dur;
    assign push     = (r_state == ptfd_pkg::ST_SHIFT) && (r_rem >= PERIOD);
    assign emit     = (r_state == ptfd_pkg::ST_EMIT) && (!r_out_valid || o_result.ready);

    // next state and working values
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_rem   = r_rem;
        n_dur   = r_dur;
        n_adj   = r_adj;
        n_level = r_level;
        n_hit   = r_hit;
        n_card  = r_card;
        unique case (r_state)
            ptfd_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    n_level = i_pulse.pulse_level;
                    n_dur   = in_dur;
                    n_phase = ptfd_pkg::PH_NORMAL;
                    n_hit   = 1'b0;
                    if (i_pulse.pulse_level) begin
                        n_adj = in_dur + ptfd_pkg::PHASE_SHIFT_US;
                    end else if (in_dur > ptfd_pkg::PHASE_SHIFT_US) begin
                        n_adj = in_dur - ptfd_pkg::PHASE_SHIFT_US;
                    end else begin
                        n_adj = in_dur;
                    end
                    n_state = (in_dur <= HALF_P) ? ptfd_pkg::ST_EMIT : ptfd_pkg::ST_PHASE;
                end
            end
            ptfd_pkg::ST_PHASE: begin
                n_rem = len_sel + HALF_P;
                if (len_sel + HALF_P >= LIMIT) begin
                    // run too long for a frame: register left alone
                    if (r_phase == ptfd_pkg::PH_INV_SHIFTED) begin
                        n_state = ptfd_pkg::ST_EMIT;
                    end else begin
                        n_phase = ptfd_pkg::t_phase'(r_phase + 2'd1);
                    end
                end else begin
                    n_state = ptfd_pkg::ST_SHIFT;
                end
            end
            ptfd_pkg::ST_SHIFT: begin
                if (push) begin
                    n_rem = r_rem - PERIOD;
                    if (ptfd_pkg::frame_ok(shifted)) begin
                        n_hit   = 1'b1;
                        n_card  = ptfd_pkg::card_of(shifted);
                        n_state = ptfd_pkg::ST_EMIT;
                    end
                end else if (r_phase == ptfd_pkg::PH_INV_SHIFTED) begin
                    n_state = ptfd_pkg::ST_EMIT;
                end else begin
                    n_phase = ptfd_pkg::t_phase'(r_phase + 2'd1);
                    n_state = ptfd_pkg::ST_PHASE;
                end
            end
            ptfd_pkg::ST_EMIT: begin
                if (emit) begin
                    n_state = ptfd_pkg::ST_IDLE;
                end
            end
            default: n_state = ptfd_pkg::ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        i_pulse.ready          = (r_state == ptfd_pkg::ST_IDLE);
        o_result.valid         = r_out_valid;
        o_result.frame_found   = r_out_found;
        o_result.card_bits     = r_out_card;
        o_result.facility_code = r_out_fc;
        o_result.card_number   = r_out_cn;
        o_result.matched_phase = r_out_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ptfd_pkg::ST_IDLE;
            r_phase     <= ptfd_pkg::PH_NORMAL;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_buf[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_hit   <= n_hit;
            if (push) begin
                r_buf[r_phase] <= shifted;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem   <= n_rem;
        r_dur   <= n_dur;
        r_adj   <= n_adj;
        r_level <= n_level;
        r_card  <= n_card;
        if (emit) begin
            r_out_found <= r_hit;
            r_out_card  <= r_hit ? r_card : '0;
            r_out_fc    <= r_hit ? ptfd_pkg::fc_of(r_card) : '0;
            r_out_cn    <= r_hit ? ptfd_pkg::cn_of(r_card) : '0;
            r_out_phase <= r_hit ? r_phase : 2'd0;
        end
    end

endmodule
